### src/skoi_pkg.sv
package skoi_pkg;

  localparam int KEY_W = 64;
  localparam int LEN_W = 32;
  localparam int OFF_W = 64;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_FIND = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_DONE
  } state_e;

  // one table row: key and the byte offset assigned to it
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic             full;
    logic [OFF_W-1:0] offset;
    logic             found;
  } result_t;

endpackage

### src/sorted_key_offset_index.sv
// Add: the result passes through res_q into the output register; the next
//   add is taken once it is loaded. Find: ST_PROBE halves the range to at
//   most 2 entries (about log2(entries) - 1 probes, 9 at 1024 entries), then
//   ST_CHK_LO/HI check the rest; one table read per cycle, single registered port.
// Not ready while a request is in work. Reset (rst_ni low, async) empties
//   the table and clears the byte total; table rows need no clearing pass.
module sorted_key_offset_index import skoi_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // slave side
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [KEY_W+LEN_W-1:0]   s_axis_tdata_i,  // [63:0] key, [95:64] length
  input  logic [0:0]               s_axis_tuser_i,  // [0] req_type
  // master side
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [OFF_W-1:0]         m_axis_tdata_o,  // [63:0] offset
  output logic [1:0]               m_axis_tuser_o   // [0] found, [1] full_res
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

  // Search sequencer state. lo/hi bound the live range [lo, hi);
  // mid is the row whose read is in flight during ST_PROBE.
  state_e           state_q, state_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [KEY_W-1:0] key_q, key_d;
  result_t          res_q, res_d;

  logic [CW-1:0]    count_q, count_d;
  logic [OFF_W-1:0] total_q, total_d;

  logic             out_valid_q;
  result_t          out_res_q;
  logic             out_load;

  logic             s_fire;
  logic             wr_en;
  entry_t           wr_data;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;

  logic             go_search;
  logic [CW-1:0]    lo_n, hi_n, span_n, mid_n;
  logic             key_lt, key_gt;

  localparam result_t Miss = '{full: 1'b0, offset: '0, found: 1'b0};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign wr_data = '{offset: total_q, key: s_axis_tdata_i[KEY_W-1:0]};

  skoi_store #(
    .Depth(MAX_ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // the probe compare: stored key against the search key (checks use their own ==)
  assign key_lt = rd_data.key < key_q;
  assign key_gt = rd_data.key > key_q;

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    key_d     = key_q;
    res_d     = res_q;
    count_d   = count_q;
    total_d   = total_q;
    wr_en     = 1'b0;
    rd_addr   = lo_q[AW-1:0];
    out_load  = 1'b0;
    go_search = 1'b0;
    lo_n      = lo_q;
    hi_n      = hi_q;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (req_e'(s_axis_tuser_i[0]))
            REQ_ADD: begin
              if (count_q >= MaxCount) begin
                res_d = '{full: 1'b1, offset: '0, found: 1'b0};
              end else begin
                wr_en   = 1'b1;
                res_d   = '{full: 1'b0, offset: total_q, found: 1'b0};
                count_d = count_q + CW'(1);
                total_d = total_q + OFF_W'(s_axis_tdata_i[KEY_W+LEN_W-1:KEY_W]);
              end
              state_d = ST_DONE;
            end
            REQ_FIND: begin
              key_d     = s_axis_tdata_i[KEY_W-1:0];
              lo_n      = '0;
              hi_n      = count_q;
              go_search = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PROBE: begin
        if (key_lt) begin
          lo_n      = mid_q;
          go_search = 1'b1;
        end else if (key_gt) begin
          hi_n      = mid_q;
          go_search = 1'b1;
        end else begin
          res_d   = '{full: 1'b0, offset: rd_data.offset, found: 1'b1};
          state_d = ST_DONE;
        end
      end
      ST_CHK_LO: begin
        if (rd_data.key == key_q) begin
          res_d   = '{full: 1'b0, offset: rd_data.offset, found: 1'b1};
          state_d = ST_DONE;
        end else begin
          rd_addr = AW'(hi_q - CW'(1));
          state_d = ST_CHK_HI;
        end
      end
      ST_CHK_HI: begin
        if (rd_data.key == key_q) begin
          res_d = '{full: 1'b0, offset: rd_data.offset, found: 1'b1};
        end else begin
          res_d = Miss;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    span_n = hi_n - lo_n;
    mid_n  = lo_n + (span_n >> 1);

    // narrow the range and launch the next read in the same cycle; an empty table gives a miss
    if (go_search) begin
      lo_d = lo_n;
      hi_d = hi_n;
      if (hi_n == '0) begin
        res_d   = Miss;
        state_d = ST_DONE;
      end else if (span_n > CW'(2)) begin
        mid_d   = mid_n;
        rd_addr = mid_n[AW-1:0];
        state_d = ST_PROBE;
      end else begin
        rd_addr = lo_n[AW-1:0];
        state_d = ST_CHK_LO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q.offset;
  assign m_axis_tuser_o  = {out_res_q.full, out_res_q.found};

  // table never holds more rows than it has
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("entry count beyond table size");

  // a rejected add is only reported while the table is full
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.full |-> count_q == MaxCount)
    else $error("full flag with room left");

  // hit and reject never come together
  a_hit_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.found && out_res_q.full))
    else $error("found and full_res both set");

  // search range stays non-empty and within the written rows
  a_range_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE || state_q == ST_CHK_LO || state_q == ST_CHK_HI)
      |-> (lo_q < hi_q) && (hi_q <= count_q))
    else $error("search range out of bounds");

endmodule

### src/skoi_store.sv
module skoi_store import skoi_pkg::*; #(
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  entry_t                   wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output entry_t                   rd_data_o
);

  entry_t mem [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
